// ----- rtl/stc_pkg.sv -----
package stc_pkg;

   localparam int unsigned DivBits = 32;

   typedef struct packed {
      logic [19:0] adc_temp;
      logic [19:0] adc_press;
      logic [15:0] adc_hum;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] temperature;
      logic [31:0]        pressure;
      logic [16:0]        humidity;
      logic               divide_guard;
   } rsp_payload_type;

   typedef struct packed {
      logic [47:0] temp_coeffs;
      logic [63:0] press_coeffs_low;
      logic [63:0] press_coeffs_high;
      logic [15:0] press_coeff_p9;
      logic [63:0] hum_coeffs;
   } coeff_type;

   localparam logic [2:0] RegTemp    = 3'd0;
   localparam logic [2:0] RegPressLo = 3'd1;
   localparam logic [2:0] RegPressHi = 3'd2;
   localparam logic [2:0] RegPressP9 = 3'd3;
   localparam logic [2:0] RegHum     = 3'd4;

   function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

// ----- rtl/stc_csr.sv -----
module stc_csr
   import stc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output coeff_type   coeff
);

   coeff_type coeff_ff;
   logic [2:0] idx;

   assign idx   = csr_paddr[5:3];
   assign coeff = coeff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            RegTemp:    coeff_ff.temp_coeffs       <= csr_pwdata[47:0];
            RegPressLo: coeff_ff.press_coeffs_low  <= csr_pwdata;
            RegPressHi: coeff_ff.press_coeffs_high <= csr_pwdata;
            RegPressP9: coeff_ff.press_coeff_p9    <= csr_pwdata[15:0];
            RegHum:     coeff_ff.hum_coeffs        <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         RegTemp:    csr_prdata = {16'd0, coeff_ff.temp_coeffs};
         RegPressLo: csr_prdata = coeff_ff.press_coeffs_low;
         RegPressHi: csr_prdata = coeff_ff.press_coeffs_high;
         RegPressP9: csr_prdata = {48'd0, coeff_ff.press_coeff_p9};
         RegHum:     csr_prdata = coeff_ff.hum_coeffs;
         default:    csr_prdata = '0;
      endcase
   end

endmodule

// ----- rtl/stc_div.sv -----
module stc_div
   import stc_pkg::*;
#(
   parameter type TAG_TYPE = logic
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [31:0] in_num,
   input  logic [31:0] in_den,
   input  TAG_TYPE     in_tag,
   output logic        out_valid,
   output logic [31:0] out_quo,
   output TAG_TYPE     out_tag
);

   logic [DivBits:1] valid_ff;
   logic [31:0]      rem_ff [1:DivBits];
   logic [31:0]      num_ff [1:DivBits];
   logic [31:0]      den_ff [1:DivBits];
   TAG_TYPE          tag_ff [1:DivBits];

   for (genvar i = 0; i < DivBits; i++) begin : g_step
      logic        valid_prev;
      logic [31:0] rem_prev;
      logic [31:0] num_prev;
      logic [31:0] den_prev;
      TAG_TYPE     tag_prev;
      logic [32:0] trial;
      logic [32:0] rem_in;
      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign num_prev   = in_num;
         assign den_prev   = in_den;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[i];
         assign rem_prev   = rem_ff[i];
         assign num_prev   = num_ff[i];
         assign den_prev   = den_ff[i];
         assign tag_prev   = tag_ff[i];
      end
      assign rem_in = {rem_prev, num_prev[31]};
      assign trial  = rem_in - {1'b0, den_prev};
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[i+1] <= valid_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!trial[32]) begin
               rem_ff[i+1] <= trial[31:0];
               num_ff[i+1] <= {num_prev[30:0], 1'b1};
            end else begin
               rem_ff[i+1] <= rem_in[31:0];
               num_ff[i+1] <= {num_prev[30:0], 1'b0};
            end
            den_ff[i+1] <= den_prev;
            tag_ff[i+1] <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[DivBits];
   assign out_quo   = num_ff[DivBits];
   assign out_tag   = tag_ff[DivBits];

endmodule

// ----- rtl/stc_pipe.sv -----
module stc_pipe
   import stc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  coeff_type       coeff,
   input  logic            in_valid,
   input  req_payload_type in_data,
   output logic            out_valid,
   output rsp_payload_type out_data
);

   typedef struct packed {
      logic [31:0] tc;
      logic [16:0] hum;
      logic        guard;
      logic        dbl;
   } tag_type;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;

   always_comb begin
      t1 = {16'd0, coeff.temp_coeffs[15:0]};
      t2 = sx16(coeff.temp_coeffs[31:16]);
      t3 = sx16(coeff.temp_coeffs[47:32]);
      p1 = {16'd0, coeff.press_coeffs_low[15:0]};
      p2 = sx16(coeff.press_coeffs_low[31:16]);
      p3 = sx16(coeff.press_coeffs_low[47:32]);
      p4 = sx16(coeff.press_coeffs_low[63:48]);
      p5 = sx16(coeff.press_coeffs_high[15:0]);
      p6 = sx16(coeff.press_coeffs_high[31:16]);
      p7 = sx16(coeff.press_coeffs_high[47:32]);
      p8 = sx16(coeff.press_coeffs_high[63:48]);
      p9 = sx16(coeff.press_coeff_p9);
      h1 = {24'd0, coeff.hum_coeffs[7:0]};
      h2 = sx16(coeff.hum_coeffs[23:8]);
      h3 = {24'd0, coeff.hum_coeffs[31:24]};
      h4 = {{20{coeff.hum_coeffs[43]}}, coeff.hum_coeffs[43:32]};
      h5 = {{20{coeff.hum_coeffs[55]}}, coeff.hum_coeffs[55:44]};
      h6 = {{24{coeff.hum_coeffs[63]}}, coeff.hum_coeffs[63:56]};
   end

   // Stage 1: temperature differences.
   logic        v1_ff;
   logic [31:0] a1_ff, dt1_ff, ap1_ff, ah1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= {15'd0, in_data.adc_temp[19:3]} - (t1 << 1);
         dt1_ff <= {16'd0, in_data.adc_temp[19:4]} - t1;
         ap1_ff <= {12'd0, in_data.adc_press};
         ah1_ff <= {16'd0, in_data.adc_hum};
      end
   end

   // Stage 2: products.
   logic        v2_ff;
   logic [31:0] lin2_ff, sq2_ff, ap2_ff, ah2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         lin2_ff <= sra(a1_ff * t2, 11);
         sq2_ff  <= sra(dt1_ff * dt1_ff, 12);
         ap2_ff  <= ap1_ff;
         ah2_ff  <= ah1_ff;
      end
   end

   // Stage 3: quadratic term.
   logic        v3_ff;
   logic [31:0] lin3_ff, q3_ff, ap3_ff, ah3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         lin3_ff <= lin2_ff;
         q3_ff   <= sra(sq2_ff * t3, 14);
         ap3_ff  <= ap2_ff;
         ah3_ff  <= ah2_ff;
      end
   end

   // Stage 4: fine temperature and first differences.
   logic        v4_ff;
   logic [31:0] tf4_ff, pa4_ff, hx4_ff, ap4_ff, ah4_ff;
   logic [31:0] tf_c;
   assign tf_c = lin3_ff + q3_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         tf4_ff <= tf_c;
         pa4_ff <= sra(tf_c, 1) - 32'd64000;
         hx4_ff <= tf_c - 32'd76800;
         ap4_ff <= ap3_ff;
         ah4_ff <= ah3_ff;
      end
   end

   // Stage 5: first products.
   logic        v5_ff;
   logic [31:0] tcm5_ff, sq5_ff, pa5_p5_ff, p2pa5_ff, pa5_ff;
   logic [31:0] h5x5_ff, hx6_5_ff, hx3_5_ff, ap5_ff, ah5_ff;
   logic [31:0] qa_c;
   assign qa_c = sra(pa4_ff, 2);
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         tcm5_ff   <= tf4_ff * 32'd5;
         sq5_ff    <= qa_c * qa_c;
         pa5_p5_ff <= pa4_ff * p5;
         p2pa5_ff  <= p2 * pa4_ff;
         pa5_ff    <= pa4_ff;
         h5x5_ff   <= h5 * hx4_ff;
         hx6_5_ff  <= sra(hx4_ff * h6, 10);
         hx3_5_ff  <= sra(hx4_ff * h3, 11) + 32'd32768;
         ap5_ff    <= ap4_ff;
         ah5_ff    <= ah4_ff;
      end
   end

   // Stage 6: second products.
   logic        v6_ff;
   logic [31:0] tc6_ff, pb6_ff, pa6_ff, hu6_ff, hv6_ff, ap6_ff;
   logic [31:0] pb_c, p3sq_c;
   assign pb_c   = sra(sq5_ff, 11) * p6;
   assign p3sq_c = p3 * sra(sq5_ff, 13);
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         tc6_ff <= sra(tcm5_ff + 32'd128, 8);
         pb6_ff <= sra(pb_c + (pa5_p5_ff << 1), 2) + (p4 << 16);
         pa6_ff <= 32'd32768 + sra(sra(p3sq_c, 3) + sra(p2pa5_ff, 1), 18);
         hu6_ff <= sra(((ah5_ff << 14) - (h4 << 20) - h5x5_ff) + 32'd16384, 15);
         hv6_ff <= sra(hx6_5_ff * hx3_5_ff, 10) + 32'd2097152;
         ap6_ff <= ap5_ff;
      end
   end

   // Stage 7: pressure divisor and humidity scale.
   logic        v7_ff;
   logic [31:0] tc7_ff, pa7_ff, r7_ff, hu7_ff, hv7_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         tc7_ff <= tc6_ff;
         pa7_ff <= sra(pa6_ff * p1, 15);
         r7_ff  <= ((32'd1048576 - ap6_ff) - sra(pb6_ff, 12)) * 32'd3125;
         hu7_ff <= hu6_ff;
         hv7_ff <= sra(hv6_ff * h2 + 32'd8192, 14);
      end
   end

   // Stage 8: humidity product.
   logic        v8_ff;
   logic [31:0] tc8_ff, pa8_ff, r8_ff, hx8_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         tc8_ff <= tc7_ff;
         pa8_ff <= pa7_ff;
         r8_ff  <= r7_ff;
         hx8_ff <= hu7_ff * hv7_ff;
      end
   end

   // Stage 9: humidity correction square.
   logic        v9_ff;
   logic [31:0] tc9_ff, pa9_ff, r9_ff, hx9_ff, hss9_ff;
   logic [31:0] hs_c;
   assign hs_c = sra(hx8_ff, 15);
   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (adv) v9_ff <= v8_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         tc9_ff  <= tc8_ff;
         pa9_ff  <= pa8_ff;
         r9_ff   <= r8_ff;
         hx9_ff  <= hx8_ff;
         hss9_ff <= sra(hs_c * hs_c, 7);
      end
   end

   // Stage 10: humidity clamp and scaling, divider set-up.
   logic        v10_ff;
   logic [31:0] num10_ff, den10_ff;
   tag_type     tag10_ff;
   logic [31:0] hxf_c, hcl_c, hsc_c;
   always_comb begin
      hxf_c = hx9_ff - sra(hss9_ff * h1, 4);
      if (hxf_c[31]) hcl_c = '0;
      else if (hxf_c > 32'd419430400) hcl_c = 32'd419430400;
      else hcl_c = hxf_c;
      hsc_c = ({12'd0, hcl_c[31:12]} * 32'd1000) >> 10;
   end
   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else if (adv) v10_ff <= v9_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         num10_ff       <= r9_ff[31] ? r9_ff : (r9_ff << 1);
         den10_ff       <= (pa9_ff == '0) ? 32'd1 : pa9_ff;
         tag10_ff.tc    <= tc9_ff;
         tag10_ff.hum   <= hsc_c[16:0];
         tag10_ff.guard <= (pa9_ff == '0);
         tag10_ff.dbl   <= r9_ff[31];
      end
   end

   logic        dv;
   logic [31:0] dq;
   tag_type     dtag;

   stc_div #(.TAG_TYPE(tag_type)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v10_ff),
      .in_num    (num10_ff),
      .in_den    (den10_ff),
      .in_tag    (tag10_ff),
      .out_valid (dv),
      .out_quo   (dq),
      .out_tag   (dtag)
   );

   // Post-division stage A: pressure correction products.
   logic        va_ff;
   logic [31:0] ra_ff, sqa_ff, da_ff;
   tag_type     taga_ff;
   logic [31:0] r_c, r3_c;
   always_comb begin
      r_c  = dtag.dbl ? (dq << 1) : dq;
      r3_c = r_c >> 3;
   end
   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (adv) va_ff <= dv;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ra_ff   <= r_c;
         sqa_ff  <= (r3_c * r3_c) >> 13;
         da_ff   <= sra((r_c >> 2) * p8, 13);
         taga_ff <= dtag;
      end
   end

   // Post-division stage B: final pressure.
   logic        vb_ff;
   rsp_payload_type resb_ff;
   logic [31:0] c_c;
   assign c_c = sra(p9 * sqa_ff, 12);
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (adv) vb_ff <= va_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         resb_ff.temperature  <= taga_ff.tc;
         resb_ff.pressure     <= taga_ff.guard ? 32'd0
                                 : ra_ff + sra(c_c + da_ff + p7, 4);
         resb_ff.humidity     <= taga_ff.hum;
         resb_ff.divide_guard <= taga_ff.guard;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = resb_ff;

endmodule

// ----- rtl/sensor_thp_compensation.sv -----
// Throughput: one sample triple per cycle; the 32-step restoring pressure divider is pipelined.
// The whole pipeline advances together and holds when the response side stalls.
// Reset is synchronous and active high; it clears the valid bits and all coefficients to zero.
module sensor_thp_compensation
   import stc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [5:0]      csr_paddr,
   input  logic [63:0]     csr_pwdata,
   output logic [63:0]     csr_prdata,
   output logic            csr_pready
);

   coeff_type coeff;
   logic      adv;

   assign adv        = !(rsp_valid && rsp_stall);
   assign req_stall  = !adv;
   assign csr_pready = 1'b1;

   stc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .coeff       (coeff)
   );

   stc_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .coeff     (coeff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

// ----- verif/sensor_thp_compensation_checker.sv -----
`timescale 1ns / 1ps

module sensor_thp_compensation_checker
   import stc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic            csr_pready,
   input  logic [5:0]      csr_paddr,
   input  logic [63:0]     csr_pwdata,
   output int              fail_count,
   output int              pending
);

   logic [47:0] t_reg;
   logic [63:0] plo_reg;
   logic [63:0] phi_reg;
   logic [15:0] p9_reg;
   logic [63:0] h_reg;
   rsp_payload_type sample_queue[$];

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] sext(input logic [63:0] r, input int pos, input int w);
      logic [31:0] v;
      v = 32'(r >> pos) & ((32'd1 << w) - 1);
      if (v[w-1]) v = v | ~((32'd1 << w) - 1);
      return v;
   endfunction

   function automatic rsp_payload_type compensate(input req_payload_type s);
      rsp_payload_type o;
      logic [31:0] at, ap, ah, t1, t2, t3, lin, dt, tf;
      logic [31:0] pa, qa, sq, pb, r, c, d, pres, hx, hu, hv, hs;
      at = 32'(s.adc_temp);
      ap = 32'(s.adc_press);
      ah = 32'(s.adc_hum);
      t1 = 32'(t_reg[15:0]);
      t2 = sext(64'(t_reg), 16, 16);
      t3 = sext(64'(t_reg), 32, 16);
      lin = asr(((at >> 3) - (t1 << 1)) * t2, 11);
      dt = (at >> 4) - t1;
      tf = lin + asr(asr(dt * dt, 12) * t3, 14);
      o.temperature = asr(tf * 5 + 128, 8);
      pa = asr(tf, 1) - 32'd64000;
      qa = asr(pa, 2);
      sq = qa * qa;
      pb = asr(sq, 11) * sext(phi_reg, 16, 16);
      pb = pb + ((pa * sext(phi_reg, 0, 16)) << 1);
      pb = asr(pb, 2) + (sext(plo_reg, 48, 16) << 16);
      pa = asr(asr(sext(plo_reg, 32, 16) * asr(sq, 13), 3)
               + asr(sext(plo_reg, 16, 16) * pa, 1), 18);
      pa = asr((32'd32768 + pa) * 32'(plo_reg[15:0]), 15);
      pres = 0;
      o.divide_guard = (pa == 0);
      if (pa != 0) begin
         r = ((32'd1048576 - ap) - asr(pb, 12)) * 32'd3125;
         if (!r[31]) r = (r << 1) / pa;
         else r = (r / pa) * 2;
         c = asr(sext(64'(p9_reg), 0, 16) * (((r >> 3) * (r >> 3)) >> 13), 12);
         d = asr((r >> 2) * sext(phi_reg, 48, 16), 13);
         pres = r + asr(c + d + sext(phi_reg, 32, 16), 4);
      end
      o.pressure = pres;
      hx = tf - 32'd76800;
      hu = asr(((ah << 14) - (sext(h_reg, 32, 12) << 20) - (sext(h_reg, 44, 12) * hx))
               + 32'd16384, 15);
      hv = asr(hx * sext(h_reg, 56, 8), 10) * (asr(hx * 32'(h_reg[31:24]), 11) + 32'd32768);
      hv = asr(hv, 10) + 32'd2097152;
      hv = asr(hv * sext(h_reg, 8, 16) + 32'd8192, 14);
      hx = hu * hv;
      hs = asr(hx, 15);
      hx = hx - asr(asr(hs * hs, 7) * 32'(h_reg[7:0]), 4);
      if (hx[31]) hx = 0;
      else if (hx > 32'd419430400) hx = 32'd419430400;
      o.humidity = 17'((((hx >> 12) * 32'd1000) / 32'd1024));
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         t_reg <= '0;
         plo_reg <= '0;
         phi_reg <= '0;
         p9_reg <= '0;
         h_reg <= '0;
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               RegTemp:    t_reg <= csr_pwdata[47:0];
               RegPressLo: plo_reg <= csr_pwdata;
               RegPressHi: phi_reg <= csr_pwdata;
               RegPressP9: p9_reg <= csr_pwdata[15:0];
               RegHum:     h_reg <= csr_pwdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) sample_queue.push_back(compensate(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (sample_queue.size() == 0) begin
               $display("%0t: unexpected beat, actual %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = sample_queue.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch, expected t=%0d p=%0d h=%0d g=%0d",
                     $time, want.temperature, want.pressure, want.humidity,
                     want.divide_guard);
                  $display("   actual t=%0d p=%0d h=%0d g=%0d",
                     rsp_data.temperature, rsp_data.pressure, rsp_data.humidity,
                     rsp_data.divide_guard);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= sample_queue.size();
      end
   end

endmodule

// ----- verif/sensor_thp_compensation_tb.sv -----
`timescale 1ns / 1ps

module sensor_thp_compensation_tb;
   import stc_pkg::*;

   logic            clock = 0;
   logic            reset = 1;
   logic            req_valid = 0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 0;
   rsp_payload_type rsp_data;
   logic            csr_psel = 0;
   logic            csr_penable = 0;
   logic            csr_pwrite = 0;
   logic [5:0]      csr_paddr = '0;
   logic [63:0]     csr_pwdata = '0;
   logic [63:0]     csr_prdata;
   logic            csr_pready;
   int              fail_count;
   int              pending;
   int              send_idle = 0;
   int              recv_stall = 0;
   int              quiet_cycles = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   sensor_thp_compensation uut (.*);

   sensor_thp_compensation_checker chk (.*);

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic send_sample(input req_payload_type s);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= s;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64;
      return {$urandom, $urandom};
   endfunction

   // Typical factory calibration, so that the pressure and humidity paths see sane values.
   task automatic load_typical;
      write_reg(RegTemp, {16'sd50, 16'sd26435, 16'd27504});
      write_reg(RegPressLo, {16'sd2855, 16'sd8191, -16'sd10685, 16'd36477});
      write_reg(RegPressHi, {-16'sd7, 16'sd15500, -16'sd14600, 16'sd140});
      write_reg(RegPressP9, 16'sd6000);
      write_reg(RegHum, {8'sd30, 12'sd50, 12'sd320, 8'd0, 16'sd360, 8'd75});
   endtask

   function automatic req_payload_type typical_sample;
      req_payload_type s;
      s.adc_temp = 20'($urandom_range(560000, 480000));
      s.adc_press = 20'($urandom_range(450000, 350000));
      s.adc_hum = 16'($urandom);
      return s;
   endfunction

   function automatic req_payload_type any_sample;
      return req_payload_type'(56'({$urandom, $urandom}));
   endfunction

   initial begin
      req_payload_type s;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // All coefficients zero: the pressure divisor is zero.
      send_sample('0);
      send_sample('1);
      drain();
      load_typical();
      send_sample('0);
      send_sample('1);
      send_sample({20'hFFFFF, 20'h0, 16'h0});
      send_sample({20'h0, 20'hFFFFF, 16'hFFFF});
      for (int i = 0; i < 10; i++) send_sample(typical_sample());
      drain();
      write_reg(RegTemp, '1);
      write_reg(RegPressLo, '1);
      write_reg(RegPressHi, '1);
      write_reg(RegPressP9, '1);
      write_reg(RegHum, '1);
      send_sample('0);
      send_sample('1);
      send_sample({20'h80000, 20'h80000, 16'h8000});
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 63; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 63; end
            default: begin send_idle = 21; recv_stall = 21; end
         endcase
         if (ph < 4) load_typical();
         else begin
            write_reg(RegTemp, rand64());
            write_reg(RegPressLo, rand64());
            write_reg(RegPressHi, rand64());
            write_reg(RegPressP9, rand64());
            write_reg(RegHum, rand64());
         end
         for (int i = 0; i < 66; i++) begin
            if ($urandom_range(3) == 0) s = any_sample();
            else s = typical_sample();
            send_sample(s);
         end
         drain();
      end
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
